// ===== rtl/axi_burst_memory_slave_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the AXI burst memory slave top level.
// ----------------------------------------------------------------------------
`ifndef AXI_BURST_MEMORY_SLAVE_TOP_ASSERT_SVH
`define AXI_BURST_MEMORY_SLAVE_TOP_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define ABMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abms: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define ABMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abms: next-cycle check failed");

`endif

// ===== rtl/abms_pkg.sv =====
// ----------------------------------------------------------------------------
// abms_pkg
// Shared types, constants and byte-lane helpers of the AXI burst memory slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package abms_pkg;

    // Memory depth in 64-bit words; must be a power of two so that byte
    // addresses wrap by dropping upper bits.
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Request sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE_LO,
        S_WRITE_HI
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mem_rd;
        logic mem_wr_lo;
        logic mem_wr_hi;
        logic commit;
    } t_dp_cmd;

    // Data mask covering the 2^size low bytes of a beat.
    function automatic logic [63:0] f_size_mask(input logic [1:0] size);
        logic [63:0] mask;
        unique case (size)
            2'd0: mask = 64'h0000_0000_0000_00FF;
            2'd1: mask = 64'h0000_0000_0000_FFFF;
            2'd2: mask = 64'h0000_0000_FFFF_FFFF;
            2'd3: mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return mask;
    endfunction

    // Byte enables covering the 2^size low bytes of a beat.
    function automatic logic [7:0] f_byte_en(input logic [1:0] size);
        logic [7:0] be;
        unique case (size)
            2'd0: be = 8'h01;
            2'd1: be = 8'h03;
            2'd2: be = 8'h0F;
            2'd3: be = 8'hFF;
        endcase
        return be;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/abms_ctrl.sv =====
// ----------------------------------------------------------------------------
// abms_ctrl
// Request sequencer: accepts one request, steps the datapath through the
// memory read, two word writes and the state commit, then strobes done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abms_ctrl
    import abms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    output logic         o_busy,
    output logic         o_done,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // State and done strobe registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ:     n_state = S_WRITE_LO;
            S_WRITE_LO: n_state = S_WRITE_HI;
            S_WRITE_HI: n_state = S_IDLE;
        endcase
    end

    // Command outputs to the datapath.
    always_comb begin
        o_cmd  = '0;
        n_done = 1'b0;
        unique case (r_state)
            S_IDLE:     o_cmd.load      = i_start;
            S_READ:     o_cmd.mem_rd    = 1'b1;
            S_WRITE_LO: o_cmd.mem_wr_lo = 1'b1;
            S_WRITE_HI: begin
                o_cmd.mem_wr_hi = 1'b1;
                o_cmd.commit    = 1'b1;
                n_done          = 1'b1;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/abms_datapath.sv =====
// ----------------------------------------------------------------------------
// abms_datapath
// Request latch, read/write channel state, byte-lane memory and the
// registered result fields of the AXI burst memory slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module abms_datapath
    import abms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic        i_ar_valid,
    input  wire logic [31:0] i_ar_addr,
    input  wire logic [7:0]  i_ar_len,
    input  wire logic [1:0]  i_ar_size,
    input  wire logic        i_r_ready,
    input  wire logic        i_aw_valid,
    input  wire logic [31:0] i_aw_addr,
    input  wire logic [7:0]  i_aw_len,
    input  wire logic [1:0]  i_aw_size,
    input  wire logic        i_w_valid,
    input  wire logic [63:0] i_w_data,
    input  wire logic        i_w_last,
    output logic             o_ar_ready,
    output logic             o_r_valid,
    output logic [63:0]      o_r_data,
    output logic             o_r_last,
    output logic             o_aw_ready,
    output logic             o_w_ready,
    output logic             o_b_valid
);

    // Latched request fields.
    logic        r_in_ar_valid;
    logic [31:0] r_in_ar_addr;
    logic [7:0]  r_in_ar_len;
    logic [1:0]  r_in_ar_size;
    logic        r_in_r_ready;
    logic        r_in_aw_valid;
    logic [31:0] r_in_aw_addr;
    logic [7:0]  r_in_aw_len;
    logic [1:0]  r_in_aw_size;
    logic        r_in_w_valid;
    logic [63:0] r_in_w_data;
    logic        r_in_w_last;

    // Channel state.
    logic        r_read_busy;
    logic [31:0] r_read_address;
    logic [7:0]  r_read_length;
    logic [1:0]  r_read_size;
    logic [8:0]  r_read_count;
    logic        r_write_busy;
    logic [31:0] r_write_address;
    logic [7:0]  r_write_length;
    logic [1:0]  r_write_size;
    logic [8:0]  r_write_count;
    logic        r_write_finished;

    logic        n_read_busy;
    logic [31:0] n_read_address;
    logic [7:0]  n_read_length;
    logic [1:0]  n_read_size;
    logic [8:0]  n_read_count;
    logic        n_r_last;
    logic        n_write_busy;
    logic [31:0] n_write_address;
    logic [7:0]  n_write_length;
    logic [1:0]  n_write_size;
    logic [8:0]  n_write_count;
    logic        n_write_finished;

    // Memory and its registered read data.
    logic [63:0] r_mem [MEM_WORDS];
    logic [63:0] r_rd_lo;
    logic [63:0] r_rd_hi;

    // Result registers.
    logic        r_out_ar_ready;
    logic        r_out_r_valid;
    logic [63:0] r_out_r_data;
    logic        r_out_r_last;
    logic        r_out_aw_ready;
    logic        r_out_w_ready;
    logic        r_out_b_valid;

    // Address decode and lane alignment signals.
    logic [2:0]        rd_off;
    logic [MEM_AW-1:0] rd_w0;
    logic [MEM_AW-1:0] rd_w1;
    logic [2:0]        wr_off;
    logic [MEM_AW-1:0] wr_w0;
    logic [MEM_AW-1:0] wr_w1;
    logic [127:0]      rd_pair;
    logic [63:0]       rd_aligned;
    logic [63:0]       rd_beat;
    logic [127:0]      wr_pair;
    logic [15:0]       wr_be;
    logic              wr_fire;
    logic [8:0]        rd_count_inc;
    logic [8:0]        wr_count_inc;

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_ar_valid <= i_ar_valid;
            r_in_ar_addr  <= i_ar_addr;
            r_in_ar_len   <= i_ar_len;
            r_in_ar_size  <= i_ar_size;
            r_in_r_ready  <= i_r_ready;
            r_in_aw_valid <= i_aw_valid;
            r_in_aw_addr  <= i_aw_addr;
            r_in_aw_len   <= i_aw_len;
            r_in_aw_size  <= i_aw_size;
            r_in_w_valid  <= i_w_valid;
            r_in_w_data   <= i_w_data;
            r_in_w_last   <= i_w_last;
        end
    end

    // Word indexes of the two words a beat may touch; the second wraps.
    assign rd_off = r_read_address[2:0];
    assign rd_w0  = r_read_address[MEM_AW+2:3];
    assign rd_w1  = rd_w0 + MEM_AW'(1);
    assign wr_off = r_write_address[2:0];
    assign wr_w0  = r_write_address[MEM_AW+2:3];
    assign wr_w1  = wr_w0 + MEM_AW'(1);

    // Read beat: align the word pair, keep 2^size bytes, and lane shift
    // single-beat bursts back to the byte offset.
    assign rd_pair    = {r_rd_hi, r_rd_lo};
    assign rd_aligned = 64'(rd_pair >> {rd_off, 3'b000});
    always_comb begin
        rd_beat = rd_aligned & f_size_mask(r_read_size);
        if (r_read_length == 8'd0) begin
            rd_beat = rd_beat << {rd_off, 3'b000};
        end
    end

    // Write beat spread over the two words with byte enables.
    assign wr_fire = r_write_busy && r_in_w_valid;
    assign wr_pair = {64'd0, r_in_w_data & f_size_mask(r_write_size)} << {wr_off, 3'b000};
    assign wr_be   = {8'd0, f_byte_en(r_write_size)} << wr_off;

    // Memory: two read ports, one byte-enabled write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rd_lo <= r_mem[rd_w0];
            r_rd_hi <= r_mem[rd_w1];
        end
        if (i_cmd.mem_wr_lo && wr_fire) begin
            for (int b = 0; b < 8; b++) begin
                if (wr_be[b]) begin
                    r_mem[wr_w0][b*8 +: 8] <= wr_pair[b*8 +: 8];
                end
            end
        end
        if (i_cmd.mem_wr_hi && wr_fire) begin
            for (int b = 0; b < 8; b++) begin
                if (wr_be[8+b]) begin
                    r_mem[wr_w1][b*8 +: 8] <= wr_pair[64 + b*8 +: 8];
                end
            end
        end
    end

    assign rd_count_inc = r_read_count + 9'd1;
    assign wr_count_inc = r_write_count + 9'd1;

    // Next channel state for one sampled tick.
    always_comb begin
        n_read_busy      = r_read_busy;
        n_read_address   = r_read_address;
        n_read_length    = r_read_length;
        n_read_size      = r_read_size;
        n_read_count     = r_read_count;
        n_r_last         = 1'b0;
        n_write_busy     = r_write_busy;
        n_write_address  = r_write_address;
        n_write_length   = r_write_length;
        n_write_size     = r_write_size;
        n_write_count    = r_write_count;
        n_write_finished = r_write_finished;

        // Read channel.
        if (!r_read_busy) begin
            if (r_in_ar_valid) begin
                n_read_busy    = 1'b1;
                n_read_address = r_in_ar_addr;
                n_read_length  = r_in_ar_len;
                n_read_size    = r_in_ar_size;
            end
        end else if (r_in_r_ready) begin
            n_read_address = r_read_address + (32'd1 << r_read_size);
            n_read_count   = rd_count_inc;
            if (rd_count_inc > {1'b0, r_read_length}) begin
                n_read_busy  = 1'b0;
                n_r_last     = 1'b1;
                n_read_count = '0;
            end
        end

        // Write channel.
        if (!r_write_busy) begin
            n_write_finished = 1'b0;
            if (r_in_aw_valid) begin
                n_write_busy    = 1'b1;
                n_write_address = r_in_aw_addr;
                n_write_length  = r_in_aw_len;
                n_write_size    = r_in_aw_size;
            end
        end else if (r_in_w_valid) begin
            n_write_address = r_write_address + (32'd1 << r_write_size);
            n_write_count   = wr_count_inc;
            if ((wr_count_inc > {1'b0, r_write_length}) || r_in_w_last) begin
                n_write_busy     = 1'b0;
                n_write_finished = 1'b1;
                n_write_count    = '0;
            end
        end
    end

    // Channel state registers, updated once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_busy      <= 1'b0;
            r_read_address   <= '0;
            r_read_length    <= '0;
            r_read_size      <= '0;
            r_read_count     <= '0;
            r_write_busy     <= 1'b0;
            r_write_address  <= '0;
            r_write_length   <= '0;
            r_write_size     <= '0;
            r_write_count    <= '0;
            r_write_finished <= 1'b0;
        end else if (i_cmd.commit) begin
            r_read_busy      <= n_read_busy;
            r_read_address   <= n_read_address;
            r_read_length    <= n_read_length;
            r_read_size      <= n_read_size;
            r_read_count     <= n_read_count;
            r_write_busy     <= n_write_busy;
            r_write_address  <= n_write_address;
            r_write_length   <= n_write_length;
            r_write_size     <= n_write_size;
            r_write_count    <= n_write_count;
            r_write_finished <= n_write_finished;
        end
    end

    // Result registers, taken from the state at the start of the tick.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_ar_ready <= !r_read_busy;
            r_out_r_valid  <= r_read_busy;
            r_out_r_data   <= r_read_busy ? rd_beat : 64'd0;
            r_out_r_last   <= n_r_last;
            r_out_aw_ready <= !r_write_busy;
            r_out_w_ready  <= r_write_busy;
            r_out_b_valid  <= !r_write_busy && r_write_finished;
        end
    end

    assign o_ar_ready = r_out_ar_ready;
    assign o_r_valid  = r_out_r_valid;
    assign o_r_data   = r_out_r_data;
    assign o_r_last   = r_out_r_last;
    assign o_aw_ready = r_out_aw_ready;
    assign o_w_ready  = r_out_w_ready;
    assign o_b_valid  = r_out_b_valid;

endmodule

`default_nettype wire

// ===== rtl/axi_burst_memory_slave_top.sv =====
// ----------------------------------------------------------------------------
// axi_burst_memory_slave_top
// AXI slave over a 64-bit byte-lane memory, stepped one sampled tick per
// request.
// ----------------------------------------------------------------------------
// Usage:
// Each request carries one tick of sampled master signals (read address,
// read ready, write address and write data channels). A request is taken
// at a rising edge where i_start is high and o_busy is low.
// The result (ready/valid flags, read data, last and write response) is
// shown for exactly one cycle with o_done high; the receiver cannot stall
// it, so it must capture the fields in that cycle.
// Sequence: the request is latched at the accepting edge; the block then
// reads the two memory words a beat may span, and the single memory write
// port stores the low and high word of a beat in turn, after which o_done
// is strobed. No new request is taken while o_busy is high.
// A new request may be taken in the same cycle that o_done is high.
// Reset (synchronous, active low) returns both channels to idle and clears
// the pending write response; memory contents are kept and must be written
// before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "axi_burst_memory_slave_top_assert.svh"

module axi_burst_memory_slave_top
    import abms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    output logic             o_done,
    input  wire logic        i_ar_valid,
    input  wire logic [31:0] i_ar_addr,
    input  wire logic [7:0]  i_ar_len,
    input  wire logic [1:0]  i_ar_size,
    input  wire logic        i_r_ready,
    input  wire logic        i_aw_valid,
    input  wire logic [31:0] i_aw_addr,
    input  wire logic [7:0]  i_aw_len,
    input  wire logic [1:0]  i_aw_size,
    input  wire logic        i_w_valid,
    input  wire logic [63:0] i_w_data,
    input  wire logic        i_w_last,
    output logic             o_ar_ready,
    output logic             o_r_valid,
    output logic [63:0]      o_r_data,
    output logic             o_r_last,
    output logic             o_aw_ready,
    output logic             o_w_ready,
    output logic             o_b_valid
);

    t_dp_cmd dp_cmd;

    // Request sequencer.
    abms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // Channel state, memory and result registers.
    abms_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_ar_valid (i_ar_valid),
        .i_ar_addr  (i_ar_addr),
        .i_ar_len   (i_ar_len),
        .i_ar_size  (i_ar_size),
        .i_r_ready  (i_r_ready),
        .i_aw_valid (i_aw_valid),
        .i_aw_addr  (i_aw_addr),
        .i_aw_len   (i_aw_len),
        .i_aw_size  (i_aw_size),
        .i_w_valid  (i_w_valid),
        .i_w_data   (i_w_data),
        .i_w_last   (i_w_last),
        .o_ar_ready (o_ar_ready),
        .o_r_valid  (o_r_valid),
        .o_r_data   (o_r_data),
        .o_r_last   (o_r_last),
        .o_aw_ready (o_aw_ready),
        .o_w_ready  (o_w_ready),
        .o_b_valid  (o_b_valid)
    );

    // An accepted request keeps the block busy on the next cycle.
    `ABMS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // The done strobe comes only once the sequencer is back to idle.
    `ABMS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    // Each channel is either idle or busy in a result.
    `ABMS_ASSERT_IMP(a_chan_excl, i_clk, i_rst_n, o_done, (o_ar_ready ^ o_r_valid) && (o_aw_ready ^ o_w_ready))
    // Last beat and write response only come from the matching channel phase.
    `ABMS_ASSERT_IMP(a_resp_phase, i_clk, i_rst_n, o_done, (!o_r_last || o_r_valid) && (!o_b_valid || o_aw_ready))

endmodule

`default_nettype wire

// ===== tb/axi_burst_memory_slave_top_tb.sv =====
// ----------------------------------------------------------------------------
// axi_burst_memory_slave_top_tb
// Self-checking bench for the AXI burst memory slave. Each request carries one
// sampled tick of the master signals. A bench-side model of both channels and
// of the byte memory predicts the result of every accepted request, and that
// prediction is compared field by field with the strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axi_burst_memory_slave_top_tb;
    import abms_pkg::*;

    localparam int BYTE_AW      = MEM_AW + 3;
    localparam int MEM_BYTES    = MEM_WORDS * 8;
    localparam int RANDOM_TICKS = 400;
    localparam int STALL_LIMIT  = 200;
    localparam int MAX_SPANS    = 48;

    // One sampled tick of the master signals.
    typedef struct {
        logic        ar_valid;
        logic [31:0] ar_addr;
        logic [7:0]  ar_len;
        logic [1:0]  ar_size;
        logic        r_ready;
        logic        aw_valid;
        logic [31:0] aw_addr;
        logic [7:0]  aw_len;
        logic [1:0]  aw_size;
        logic        w_valid;
        logic [63:0] w_data;
        logic        w_last;
    } t_bus_tick;

    // What the slave shows the master for one tick.
    typedef struct {
        logic        ar_ready;
        logic        r_valid;
        logic [63:0] r_data;
        logic        r_last;
        logic        aw_ready;
        logic        w_ready;
        logic        b_valid;
    } t_bus_view;

    // A stretch of bytes laid down by one finished write burst.
    typedef struct {
        logic [BYTE_AW-1:0] origin;
        int                 nbytes;
    } t_span;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        o_done;
    logic        i_ar_valid;
    logic [31:0] i_ar_addr;
    logic [7:0]  i_ar_len;
    logic [1:0]  i_ar_size;
    logic        i_r_ready;
    logic        i_aw_valid;
    logic [31:0] i_aw_addr;
    logic [7:0]  i_aw_len;
    logic [1:0]  i_aw_size;
    logic        i_w_valid;
    logic [63:0] i_w_data;
    logic        i_w_last;
    logic        o_ar_ready;
    logic        o_r_valid;
    logic [63:0] o_r_data;
    logic        o_r_last;
    logic        o_aw_ready;
    logic        o_w_ready;
    logic        o_b_valid;

    axi_burst_memory_slave_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .i_ar_valid (i_ar_valid),
        .i_ar_addr  (i_ar_addr),
        .i_ar_len   (i_ar_len),
        .i_ar_size  (i_ar_size),
        .i_r_ready  (i_r_ready),
        .i_aw_valid (i_aw_valid),
        .i_aw_addr  (i_aw_addr),
        .i_aw_len   (i_aw_len),
        .i_aw_size  (i_aw_size),
        .i_w_valid  (i_w_valid),
        .i_w_data   (i_w_data),
        .i_w_last   (i_w_last),
        .o_ar_ready (o_ar_ready),
        .o_r_valid  (o_r_valid),
        .o_r_data   (o_r_data),
        .o_r_last   (o_r_last),
        .o_aw_ready (o_aw_ready),
        .o_w_ready  (o_w_ready),
        .o_b_valid  (o_b_valid)
    );

    // Model of the slave state, starting from its reset values.
    logic        rd_busy  = 1'b0;
    logic [31:0] rd_addr  = '0;
    logic [7:0]  rd_len   = '0;
    logic [1:0]  rd_size  = '0;
    logic [8:0]  rd_beats = '0;
    logic        wr_busy  = 1'b0;
    logic [31:0] wr_addr  = '0;
    logic [7:0]  wr_len   = '0;
    logic [1:0]  wr_size  = '0;
    logic [8:0]  wr_beats = '0;
    logic        wr_resp_pending = 1'b0;
    logic [7:0]  model_bytes [MEM_BYTES];

    // Bytes written so far, so that reads only walk through written memory.
    logic [BYTE_AW-1:0] burst_origin = '0;
    int                 burst_bytes  = 0;
    t_span              written_spans [$];

    t_bus_view expected_views [$];
    t_bus_view want_view;
    int        mismatches     = 0;
    int        stalled_cycles = 0;
    bit        gaps_on        = 1'b1;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the model by one tick and return what the slave should show.
    task automatic advance_bus_model(input t_bus_tick t, output t_bus_view v);
        logic [31:0] byte_addr;
        int          nb;
        int          i;
        v = '{default: '0};

        // Read channel: it samples memory before this tick's write lands.
        if (!rd_busy) begin
            v.ar_ready = 1'b1;
            if (t.ar_valid) begin
                rd_busy = 1'b1;
                rd_addr = t.ar_addr;
                rd_len  = t.ar_len;
                rd_size = t.ar_size;
            end
        end else begin
            v.r_valid = 1'b1;
            nb = 1 << rd_size;
            for (i = 0; i < nb; i++) begin
                byte_addr = rd_addr + i;
                v.r_data[i*8 +: 8] = model_bytes[byte_addr[BYTE_AW-1:0]];
            end
            // Single-beat reads come back on their byte lanes.
            if (rd_len == 8'd0) begin
                v.r_data = v.r_data << (8 * rd_addr[2:0]);
            end
            if (t.r_ready) begin
                rd_addr  = rd_addr + (32'd1 << rd_size);
                rd_beats = rd_beats + 9'd1;
                if (rd_beats > {1'b0, rd_len}) begin
                    rd_busy  = 1'b0;
                    v.r_last = 1'b1;
                    rd_beats = '0;
                end
            end
        end

        // Write channel: the response shows on the idle tick after a burst.
        if (!wr_busy) begin
            v.aw_ready      = 1'b1;
            v.b_valid       = wr_resp_pending;
            wr_resp_pending = 1'b0;
            if (t.aw_valid) begin
                wr_busy      = 1'b1;
                wr_addr      = t.aw_addr;
                wr_len       = t.aw_len;
                wr_size      = t.aw_size;
                burst_origin = t.aw_addr[BYTE_AW-1:0];
                burst_bytes  = 0;
            end
        end else begin
            v.w_ready = 1'b1;
            if (t.w_valid) begin
                nb = 1 << wr_size;
                for (i = 0; i < nb; i++) begin
                    byte_addr = wr_addr + i;
                    model_bytes[byte_addr[BYTE_AW-1:0]] = t.w_data[i*8 +: 8];
                end
                wr_addr     = wr_addr + (32'd1 << wr_size);
                burst_bytes = burst_bytes + nb;
                wr_beats    = wr_beats + 9'd1;
                if (wr_beats > {1'b0, wr_len} || t.w_last) begin
                    wr_busy         = 1'b0;
                    wr_resp_pending = 1'b1;
                    wr_beats        = '0;
                    written_spans.push_back('{burst_origin, burst_bytes});
                    if (written_spans.size() > MAX_SPANS) begin
                        void'(written_spans.pop_front());
                    end
                end
            end
        end
    endtask

    // Idle time before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!gaps_on) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(24, 4);
    endfunction

    // Send one request and queue the result the model predicts for it.
    task automatic send_bus_tick(input t_bus_tick t);
        t_bus_view v;
        int        gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_ar_valid <= t.ar_valid;
        i_ar_addr  <= t.ar_addr;
        i_ar_len   <= t.ar_len;
        i_ar_size  <= t.ar_size;
        i_r_ready  <= t.r_ready;
        i_aw_valid <= t.aw_valid;
        i_aw_addr  <= t.aw_addr;
        i_aw_len   <= t.aw_len;
        i_aw_size  <= t.aw_size;
        i_w_valid  <= t.w_valid;
        i_w_data   <= t.w_data;
        i_w_last   <= t.w_last;
        i_start    <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        advance_bus_model(t, v);
        expected_views.push_back(v);
    endtask

    function automatic t_bus_tick quiet_tick();
        t_bus_tick t;
        t = '{default: '0};
        return t;
    endfunction

    function automatic t_bus_tick noise_tick();
        t_bus_tick t;
        t.ar_valid = $urandom_range(1);
        t.ar_addr  = $urandom();
        t.ar_len   = $urandom();
        t.ar_size  = $urandom();
        t.r_ready  = $urandom_range(1);
        t.aw_valid = $urandom_range(1);
        t.aw_addr  = $urandom();
        t.aw_len   = $urandom();
        t.aw_size  = $urandom();
        t.w_valid  = $urandom_range(1);
        t.w_data   = {$urandom(), $urandom()};
        t.w_last   = $urandom_range(1);
        return t;
    endfunction

    // Keep running bursts moving, without opening new ones or cutting writes.
    function automatic t_bus_tick dense_tick();
        t_bus_tick t;
        t = noise_tick();
        t.ar_valid = 1'b0;
        t.aw_valid = 1'b0;
        t.w_last   = 1'b0;
        t.r_ready  = $urandom_range(9) != 0;
        t.w_valid  = $urandom_range(9) != 0;
        return t;
    endfunction

    // Open a read burst that stays inside one stretch of written bytes.
    function automatic void aim_read(inout t_bus_tick t);
        t_span      s;
        logic [1:0] sz;
        int         unit;
        int         o;
        int         fit;
        int         pick;
        s  = written_spans[$urandom_range(written_spans.size() - 1)];
        sz = $urandom_range(3);
        while ((1 << sz) > s.nbytes) sz--;
        unit = 1 << sz;
        o    = $urandom_range(1) ? 0 : $urandom_range(s.nbytes - unit);
        fit  = (s.nbytes - o) / unit;
        if (fit > 256) begin
            fit = 256;
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            t.ar_len = $urandom_range(fit > 8 ? 7 : fit - 1);
        end else if (pick < 95) begin
            t.ar_len = $urandom_range(fit - 1);
        end else begin
            t.ar_len = fit - 1;
        end
        t.ar_valid = 1'b1;
        t.ar_size  = sz;
        t.ar_addr  = $urandom();
        t.ar_addr[BYTE_AW-1:0] = s.origin + o[BYTE_AW-1:0];
    endfunction

    // Mostly well-formed bursts with random content, plus ignored noise and
    // write bursts cut short by an early last.
    function automatic t_bus_tick random_bus_tick();
        t_bus_tick t;
        int        pick;
        t = noise_tick();
        t.r_ready = $urandom_range(9) < 7;
        t.w_valid = $urandom_range(9) < 7;
        t.w_last  = $urandom_range(19) == 0;
        if (!rd_busy) begin
            t.ar_valid = 1'b0;
            if (written_spans.size() != 0 && $urandom_range(2) == 0) begin
                aim_read(t);
            end
        end
        if (!wr_busy) begin
            t.aw_valid = $urandom_range(2) == 0;
            pick = $urandom_range(99);
            if (pick < 85) begin
                t.aw_len = $urandom_range(7);
            end else if (pick < 98) begin
                t.aw_len = $urandom_range(63, 8);
            end else begin
                t.aw_len = 8'd255;
            end
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100) begin
            $display("%0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s mismatch: got %h, expected %h", name, got, want));
        end
    endtask

    // Compare every strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_views.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                want_view = expected_views.pop_front();
                check_field("ar_ready", o_ar_ready, want_view.ar_ready);
                check_field("r_valid", o_r_valid, want_view.r_valid);
                check_field("r_data", o_r_data, want_view.r_data);
                check_field("r_last", o_r_last, want_view.r_last);
                check_field("aw_ready", o_aw_ready, want_view.aw_ready);
                check_field("w_ready", o_w_ready, want_view.w_ready);
                check_field("b_valid", o_b_valid, want_view.b_valid);
            end
        end
    end

    // Watchdog: end the run when neither side makes progress for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("axi_burst_memory_slave_top_tb: FAIL");
                $finish;
            end
        end
    end

    // Both channels idle after reset; inputs of idle channels are ignored.
    task automatic test_idle_after_reset();
        t_bus_tick t;
        t = quiet_tick();
        t.ar_addr = '1;
        t.w_valid = 1'b1;
        t.w_data  = '1;
        t.w_last  = 1'b1;
        send_bus_tick(t);
    endtask

    // Writes that wrap the 32-bit address, stall, and end on an early last.
    task automatic test_write_wrap_and_early_last();
        t_bus_tick t;
        int        n;
        t = quiet_tick();
        t.aw_valid = 1'b1;
        t.aw_addr  = 32'hFFFF_FFFC;
        t.aw_len   = 8'd1;
        t.aw_size  = 2'd3;
        send_bus_tick(t);
        t = quiet_tick();
        t.w_valid = 1'b1;
        t.w_data  = '1;
        send_bus_tick(t);
        send_bus_tick(quiet_tick());
        t.w_data = 64'h0123_4567_89AB_CDEF;
        send_bus_tick(t);

        // The response tick also opens a byte burst with the longest length.
        t = quiet_tick();
        t.aw_valid = 1'b1;
        t.aw_addr  = 32'h0000_0100;
        t.aw_len   = 8'd255;
        t.aw_size  = 2'd0;
        send_bus_tick(t);
        t = quiet_tick();
        t.w_valid = 1'b1;
        t.w_data  = 64'hFFFF_FFFF_FFFF_FF5A;
        send_bus_tick(t);
        t.w_data = 64'h0000_0000_0000_00A5;
        t.w_last = 1'b1;
        send_bus_tick(t);

        // Address above the memory size folds back into it.
        t = quiet_tick();
        t.aw_valid = 1'b1;
        t.aw_addr  = 32'h8000_0200;
        t.aw_len   = 8'd3;
        t.aw_size  = 2'd2;
        send_bus_tick(t);
        t = quiet_tick();
        t.w_valid = 1'b1;
        for (n = 0; n < 4; n++) begin
            t.w_data = {$urandom(), $urandom()};
            send_bus_tick(t);
        end
        send_bus_tick(quiet_tick());
    endtask

    task automatic read_one_beat(input logic [31:0] addr, input logic [1:0] size,
                                 input bit stall);
        t_bus_tick t;
        t = quiet_tick();
        t.ar_valid = 1'b1;
        t.ar_addr  = addr;
        t.ar_size  = size;
        send_bus_tick(t);
        t = quiet_tick();
        if (stall) begin
            send_bus_tick(t);
        end
        t.r_ready = 1'b1;
        send_bus_tick(t);
    endtask

    // Single-beat reads land on the lanes of their address; high bytes that
    // shift past the top of the data bus are lost.
    task automatic test_single_beat_lanes();
        read_one_beat(32'hFFFF_FFFC, 2'd3, 1'b1);
        read_one_beat(32'h0000_0101, 2'd0, 1'b0);
        read_one_beat(32'h0000_0206, 2'd1, 1'b0);
        read_one_beat(32'h0000_020B, 2'd2, 1'b0);
    endtask

    // A read and a write walk the same bytes in the same ticks; the read must
    // see the data from before each tick's write.
    task automatic test_read_during_write();
        t_bus_tick t;
        t = quiet_tick();
        t.ar_valid = 1'b1;
        t.ar_addr  = 32'h0000_0200;
        t.ar_len   = 8'd1;
        t.ar_size  = 2'd3;
        t.aw_valid = 1'b1;
        t.aw_addr  = 32'h0000_0200;
        t.aw_len   = 8'd1;
        t.aw_size  = 2'd3;
        send_bus_tick(t);
        t = quiet_tick();
        t.r_ready = 1'b1;
        t.w_valid = 1'b1;
        t.w_data  = 64'hDEAD_BEEF_0BAD_F00D;
        send_bus_tick(t);
        t.w_data = 64'h5555_AAAA_3333_CCCC;
        send_bus_tick(t);
        send_bus_tick(quiet_tick());
    endtask

    // Bursts of the full 256 beats on both channels at once.
    task automatic test_full_length_bursts();
        t_bus_tick   t;
        logic [31:0] origin;
        origin = $urandom();

        // Lay down the 256 bytes that the long byte-wide read walks through.
        t = quiet_tick();
        t.aw_valid = 1'b1;
        t.aw_addr  = origin;
        t.aw_len   = 8'd31;
        t.aw_size  = 2'd3;
        send_bus_tick(t);
        while (wr_busy) send_bus_tick(dense_tick());

        t = dense_tick();
        t.ar_valid = 1'b1;
        t.ar_addr  = $urandom();
        t.ar_addr[BYTE_AW-1:0] = origin[BYTE_AW-1:0];
        t.ar_len   = 8'd255;
        t.ar_size  = 2'd0;
        t.aw_valid = 1'b1;
        t.aw_addr  = origin;
        t.aw_len   = 8'd255;
        t.aw_size  = 2'd3;
        send_bus_tick(t);
        while (rd_busy || wr_busy) send_bus_tick(dense_tick());
    endtask

    // Random traffic, with stretches where the sender never pauses.
    task automatic test_random_traffic();
        int n;
        for (n = 0; n < RANDOM_TICKS; n++) begin
            if (n % 40 == 0) begin
                gaps_on = $urandom_range(3) != 0;
            end
            send_bus_tick(random_bus_tick());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_ar_valid = 1'b0;
        i_ar_addr  = '0;
        i_ar_len   = '0;
        i_ar_size  = '0;
        i_r_ready  = 1'b0;
        i_aw_valid = 1'b0;
        i_aw_addr  = '0;
        i_aw_len   = '0;
        i_aw_size  = '0;
        i_w_valid  = 1'b0;
        i_w_data   = '0;
        i_w_last   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_write_wrap_and_early_last();
        test_single_beat_lanes();
        test_read_during_write();
        test_full_length_bursts();
        test_random_traffic();

        // Stop requesting, then let the last results drain.
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("axi_burst_memory_slave_top_tb: PASS");
        end else begin
            $display("axi_burst_memory_slave_top_tb: FAIL");
        end
        $finish;
    end

endmodule
